FILE: rtl/ptri_pkg.sv
// shared types and constants for the patricia trie block
package ptri_pkg;

  localparam int unsigned IN_KEY_W  = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned LEVEL_W   = 4;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_FULL      = 3'd4,
    ST_RESERVED  = 3'd5
  } status_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_DECIDE,
    S_DIFF,
    S_LINK_RD,
    S_LINK_CHK,
    S_WRITE_NODE,
    S_WRITE_PARENT,
    S_REP_RD,
    S_REP_L,
    S_REP_R,
    S_REP_K,
    S_OUT
  } state_t;

endpackage

FILE: rtl/ptri_if.sv
// valid/ready channel carrying one item of request or result
interface ptri_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] key;
  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface ptri_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  node_level;
  logic [15:0] left_key;
  logic [15:0] right_key;
  modport source (output valid, output status, output node_level, output left_key,
                  output right_key, input ready);
  modport sink   (input valid, input status, input node_level, input left_key,
                  input right_key, output ready);
endinterface

FILE: rtl/patricia_trie_insert_lookup.sv
// patricia trie insert and lookup over a node memory with one shared read port
//
//  channel | dir | payload                                   | handshake
//  req     | in  | operation, key                            | valid/ready
//  rsp     | out | status, node_level, left_key, right_key   | valid/ready
//
// a search walk reads and checks each node visited in S_WALK_RD and S_WALK_CHK, at most
// KEY_BITS+2 nodes; a lookup then passes S_DECIDE and, on a hit, S_REP_RD, S_REP_L,
// S_REP_R and S_REP_K; an insert adds a bit scan in S_DIFF, a link walk through
// S_LINK_RD and S_LINK_CHK per node (at most KEY_BITS+1) and S_WRITE_NODE, S_WRITE_PARENT;
// reset clears the fsm, the node count and the header; no clearing pass is needed
// req.ready is high only in idle; a result waits in the output register until taken,
// and the block returns to idle before the next item is accepted
module patricia_trie_insert_lookup #(
  parameter int KEY_BITS   = 16,
  parameter int NODE_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst,
  ptri_req_if.sink      req,
  ptri_rsp_if.source    rsp
);

  localparam int AW = $clog2(NODE_COUNT + 1);
  localparam int LW = $clog2(KEY_BITS) + 1;   // signed level, header is minus one
  localparam int CW = $clog2(KEY_BITS + 3);

  typedef logic signed [LW-1:0] lvl_t;
  typedef logic [AW-1:0]        addr_t;
  typedef logic [KEY_BITS-1:0]  key_t;

  // node memory (entries beyond the header are only read after being written)
  key_t  mem_key [NODE_COUNT+1];
  lvl_t  mem_lvl [NODE_COUNT+1];
  addr_t mem_lft [NODE_COUNT+1];
  addr_t mem_rgt [NODE_COUNT+1];

  // header kept in flip-flops so reset restores it at once
  addr_t hdr_lft, hdr_rgt;

  ptri_pkg::state_t state, state_next;

  logic  op;
  key_t  k;
  addr_t rd_addr, rd_addr_q;
  key_t  rd_key;
  lvl_t  rd_lvl;
  addr_t rd_lft, rd_rgt;
  key_t  nk;
  lvl_t  nl;
  addr_t nlft, nrgt;

  addr_t cur, parent, t_node, new_node;
  lvl_t  prev, par_lvl, diff;
  key_t  t_key;
  logic [CW-1:0] steps;
  logic [AW-1:0] used;

  logic [2:0]  o_status;
  logic [3:0]  o_level;
  logic [15:0] o_left, o_right;
  logic        o_valid;

  logic  wr_en;
  addr_t wr_addr;
  key_t  wr_key;
  lvl_t  wr_lvl;
  addr_t wr_lft, wr_rgt;
  logic  lnk_wr;
  logic  lnk_dir;

  // one read port with registered address, header bypass
  // node write and parent link patch in memory happen in different cycles
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    nk <= mem_key[rd_addr];
    nl <= mem_lvl[rd_addr];
    nlft <= mem_lft[rd_addr];
    nrgt <= mem_rgt[rd_addr];
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_lvl[wr_addr] <= wr_lvl;
      mem_lft[wr_addr] <= wr_lft;
      mem_rgt[wr_addr] <= wr_rgt;
    end
    if (lnk_wr) begin
      if (lnk_dir) mem_rgt[parent] <= new_node;
      else mem_lft[parent] <= new_node;
    end
  end

  always_comb begin
    if (rd_addr_q == '0) begin
      rd_key = '1;
      rd_lvl = lvl_t'(-1);
      rd_lft = hdr_lft;
      rd_rgt = hdr_rgt;
    end else begin
      rd_key = nk;
      rd_lvl = nl;
      rd_lft = nlft;
      rd_rgt = nrgt;
    end
  end

  function automatic logic kbit(key_t kk, lvl_t l);
    logic r;
    r = 1'b0;
    if (l >= 0 && int'(l) < KEY_BITS) r = kk[KEY_BITS-1-int'(l)];
    return r;
  endfunction

  logic  go_bit;
  addr_t go_link;
  always_comb begin
    go_bit  = kbit(k, rd_lvl);
    go_link = go_bit ? rd_rgt : rd_lft;
  end

  // next state and read address
  always_comb begin
    state_next = state;
    rd_addr = cur;
    wr_en = 1'b0;
    wr_addr = new_node;
    wr_key = k;
    wr_lvl = diff;
    wr_lft = kbit(k, diff) ? cur : new_node;
    wr_rgt = kbit(k, diff) ? new_node : cur;
    lnk_wr = 1'b0;
    lnk_dir = kbit(k, par_lvl);
    case (state)
      ptri_pkg::S_IDLE: begin
        // the reserved key answers at once
        if (req.valid) begin
          if (key_t'(req.key) == '1) state_next = ptri_pkg::S_OUT;
          else state_next = ptri_pkg::S_WALK_RD;
        end
      end
      ptri_pkg::S_WALK_RD:  state_next = ptri_pkg::S_WALK_CHK;
      ptri_pkg::S_WALK_CHK: begin
        if (rd_lvl > prev && int'(steps) <= KEY_BITS + 1) state_next = ptri_pkg::S_WALK_RD;
        else state_next = ptri_pkg::S_DECIDE;
      end
      ptri_pkg::S_DECIDE: begin
        if (op == ptri_pkg::OP_LOOKUP)
          state_next = (t_key == k) ? ptri_pkg::S_REP_RD : ptri_pkg::S_OUT;
        else if (t_key == k || int'(used) >= NODE_COUNT) state_next = ptri_pkg::S_OUT;
        else state_next = ptri_pkg::S_DIFF;
      end
      ptri_pkg::S_DIFF: begin
        if (!(int'(diff) < KEY_BITS - 1 && kbit(k, diff) == kbit(t_key, diff)))
          state_next = ptri_pkg::S_LINK_RD;
      end
      ptri_pkg::S_LINK_RD:  state_next = ptri_pkg::S_LINK_CHK;
      ptri_pkg::S_LINK_CHK: begin
        if (rd_lvl >= diff || rd_lvl <= par_lvl) state_next = ptri_pkg::S_WRITE_NODE;
        else state_next = ptri_pkg::S_LINK_RD;
      end
      ptri_pkg::S_WRITE_NODE: begin
        wr_en = 1'b1;
        state_next = ptri_pkg::S_WRITE_PARENT;
      end
      ptri_pkg::S_WRITE_PARENT: begin
        // the header link lives in flip-flops, other parents in memory
        lnk_wr = (parent != '0);
        state_next = ptri_pkg::S_REP_RD;
      end
      ptri_pkg::S_REP_RD: begin
        rd_addr = t_node;
        state_next = ptri_pkg::S_REP_L;
      end
      ptri_pkg::S_REP_L: begin
        rd_addr = rd_lft;
        state_next = ptri_pkg::S_REP_R;
      end
      ptri_pkg::S_REP_R: begin
        rd_addr = cur;
        state_next = ptri_pkg::S_REP_K;
      end
      ptri_pkg::S_REP_K: state_next = ptri_pkg::S_OUT;
      ptri_pkg::S_OUT: begin
        if (rsp.ready) state_next = ptri_pkg::S_IDLE;
      end
      default: state_next = ptri_pkg::S_IDLE;
    endcase
  end

  assign req.ready = (state == ptri_pkg::S_IDLE);
  assign rsp.valid = o_valid;
  assign rsp.status = o_status;
  assign rsp.node_level = o_level;
  assign rsp.left_key = o_left;
  assign rsp.right_key = o_right;

  // report needs node, then its left target, then its right target
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptri_pkg::S_IDLE;
      used <= '0;
      cur <= '0;
      hdr_lft <= '0;
      hdr_rgt <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ptri_pkg::S_IDLE: begin
          if (req.valid) begin
            op <= req.operation;
            k <= key_t'(req.key);
            cur <= hdr_lft;
            parent <= '0;
            prev <= lvl_t'(-1);
            par_lvl <= lvl_t'(-1);
            steps <= '0;
            diff <= '0;
            o_level <= '0;
            o_left <= '0;
            o_right <= '0;
            if (key_t'(req.key) == '1) begin
              o_status <= ptri_pkg::ST_RESERVED;
              o_valid <= 1'b1;
            end else begin
              o_status <= ptri_pkg::ST_NOT_FOUND;
            end
          end
        end
        ptri_pkg::S_WALK_CHK: begin
          if (rd_lvl > prev && int'(steps) <= KEY_BITS + 1) begin
            prev <= rd_lvl;
            cur <= (int'(go_link) <= NODE_COUNT) ? go_link : '0;
            steps <= steps + 1'b1;
          end else begin
            t_node <= cur;
            t_key <= rd_key;
          end
        end
        ptri_pkg::S_DECIDE: begin
          if (op == ptri_pkg::OP_LOOKUP) begin
            if (t_key == k) o_status <= ptri_pkg::ST_FOUND;
            else o_valid <= 1'b1;
          end else if (t_key == k) begin
            o_status <= ptri_pkg::ST_PRESENT;
            o_valid <= 1'b1;
          end else if (int'(used) >= NODE_COUNT) begin
            o_status <= ptri_pkg::ST_FULL;
            o_valid <= 1'b1;
          end else begin
            cur <= hdr_lft;
            new_node <= used + 1'b1;
          end
        end
        ptri_pkg::S_DIFF: begin
          if (int'(diff) < KEY_BITS - 1 && kbit(k, diff) == kbit(t_key, diff))
            diff <= diff + 1'b1;
        end
        ptri_pkg::S_LINK_CHK: begin
          if (!(rd_lvl >= diff || rd_lvl <= par_lvl)) begin
            parent <= cur;
            par_lvl <= rd_lvl;
            cur <= (int'(go_link) <= NODE_COUNT) ? go_link : '0;
          end
        end
        ptri_pkg::S_WRITE_NODE: begin
          if (parent == '0) hdr_lft <= new_node;
        end
        ptri_pkg::S_WRITE_PARENT: begin
          used <= new_node;
          t_node <= new_node;
          o_status <= ptri_pkg::ST_INSERTED;
        end
        ptri_pkg::S_REP_L: begin
          // node data here; keep its right link for the last read
          o_level <= rd_lvl[3:0];
          cur <= rd_rgt;
        end
        ptri_pkg::S_REP_R: begin
          o_left <= 16'(rd_key);
        end
        ptri_pkg::S_REP_K: begin
          o_right <= 16'(rd_key);
          o_valid <= 1'b1;
        end
        ptri_pkg::S_OUT: begin
          if (o_valid && rsp.ready) o_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    int'(used) <= NODE_COUNT) else $error("node count overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");

endmodule

FILE: verif/tb_patricia_trie_insert_lookup.sv
// testbench for the patricia trie insert and lookup block
module tb_patricia_trie_insert_lookup;

  localparam int KBITS    = 16;
  localparam int NODES    = 256;
  localparam int WDOG_MAX = 20000;
  localparam logic [15:0] ALL_ONES = 16'hFFFF;

  typedef struct packed {
    ptri_pkg::status_t status;
    logic [3:0]  level;
    logic [15:0] lkey;
    logic [15:0] rkey;
  } trie_result_t;

  // scoreboard: own copy of the trie, predicts one result per request
  class trie_scoreboard;
    logic [15:0] keys  [0:NODES];
    int          lvls  [0:NODES];
    int          lnk_l [0:NODES];
    int          lnk_r [0:NODES];
    int          used;
    trie_result_t pending[$];
    int          errors;
    int          n_checked;
    int          status_seen[6];

    function new();
      int i;
      for (i = 0; i <= NODES; i++) begin
        keys[i] = '0; lvls[i] = 0; lnk_l[i] = 0; lnk_r[i] = 0;
      end
      keys[0] = ALL_ONES;
      lvls[0] = -1;
      used = 0;
      errors = 0;
      n_checked = 0;
    endfunction

    function logic bit_at(logic [15:0] k, int lv);
      if (lv < 0 || lv >= KBITS) return 1'b0;
      return k[KBITS - 1 - lv];
    endfunction

    function int step_down(int n, logic [15:0] k);
      return bit_at(k, lvls[n]) ? lnk_r[n] : lnk_l[n];
    endfunction

    // descend until a back link is taken
    function int search(logic [15:0] k);
      int cur;
      int prev;
      int steps;
      cur = lnk_l[0];
      prev = -1;
      steps = 0;
      while (lvls[cur] > prev && steps <= KBITS + 1) begin
        prev = lvls[cur];
        cur = step_down(cur, k);
        steps++;
      end
      return cur;
    endfunction

    function trie_result_t describe(int n, ptri_pkg::status_t st);
      trie_result_t r;
      r.status = st;
      r.level  = lvls[n][3:0];
      r.lkey   = keys[lnk_l[n]];
      r.rkey   = keys[lnk_r[n]];
      return r;
    endfunction

    // note an accepted request and queue the result it must give
    function void note_request(logic op, logic [15:0] k);
      trie_result_t r;
      int t, dif, par, cur, n;
      r = '0;
      if (k == ALL_ONES) begin
        r.status = ptri_pkg::ST_RESERVED;
      end else begin
        t = search(k);
        if (op == ptri_pkg::OP_LOOKUP) begin
          if (keys[t] == k) r = describe(t, ptri_pkg::ST_FOUND);
          else r.status = ptri_pkg::ST_NOT_FOUND;
        end else if (keys[t] == k) begin
          r.status = ptri_pkg::ST_PRESENT;
        end else if (used >= NODES) begin
          r.status = ptri_pkg::ST_FULL;
        end else begin
          dif = 0;
          while (dif < KBITS - 1 && bit_at(k, dif) == bit_at(keys[t], dif)) dif++;
          par = 0;
          cur = lnk_l[0];
          while (!(lvls[cur] >= dif || lvls[cur] <= lvls[par])) begin
            par = cur;
            cur = step_down(cur, k);
          end
          n = used + 1;
          keys[n] = k;
          lvls[n] = dif;
          if (!bit_at(k, dif)) begin
            lnk_l[n] = n; lnk_r[n] = cur;
          end else begin
            lnk_l[n] = cur; lnk_r[n] = n;
          end
          if (par == 0 || !bit_at(k, lvls[par])) lnk_l[par] = n;
          else lnk_r[par] = n;
          used = n;
          r = describe(n, ptri_pkg::ST_INSERTED);
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(trie_result_t got);
      trie_result_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d", got.status));
        return;
      end
      exp = pending.pop_front();
      n_checked++;
      if (exp.status <= ptri_pkg::ST_RESERVED) status_seen[exp.status]++;
      if (got.status !== exp.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.level !== exp.level)
        report_mismatch($sformatf("node_level %0d, want %0d", got.level, exp.level));
      if (got.lkey !== exp.lkey)
        report_mismatch($sformatf("left_key %h, want %h", got.lkey, exp.lkey));
      if (got.rkey !== exp.rkey)
        report_mismatch($sformatf("right_key %h, want %h", got.rkey, exp.rkey));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("mismatch on result %0d: %s", n_checked, msg);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptri_req_if req ();
  ptri_rsp_if rsp ();

  patricia_trie_insert_lookup #(.KEY_BITS(KBITS), .NODE_COUNT(NODES)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #5 clk = ~clk;

  trie_scoreboard sb;
  int send_idle_pct;   // chance per cycle that the sender holds back
  int recv_stall_pct;  // chance per cycle that the receiver stalls
  int wdog;
  int n_sent;
  logic [15:0] inserted_keys[$];

  initial begin
    req.valid = 1'b0;
    req.operation = ptri_pkg::OP_LOOKUP;
    req.key = '0;
    rsp.ready = 1'b0;
  end

  // receiver: random stalls, check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_result('{ptri_pkg::status_t'(rsp.status), rsp.node_level, rsp.left_key,
                          rsp.right_key});
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no item accepted on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("timeout: nothing accepted for %0d cycles", WDOG_MAX);
        $display("tb_patricia_trie_insert_lookup: errors");
        $finish;
      end
    end
  end

  // hand one request over; optional idle cycles come first
  // valid stays up after an accept so back to back items keep it high
  task automatic send_request(logic op, logic [15:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.key <= k;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, k);
    if (op == ptri_pkg::OP_INSERT && k != ALL_ONES) inserted_keys.push_back(k);
    n_sent++;
  endtask

  // mostly keys already inserted or near them, some the reserved key, the rest fully random
  function automatic logic [15:0] pick_key();
    int sel;
    logic [15:0] k;
    sel = $urandom_range(99);
    if (sel < 40 && inserted_keys.size() > 0) begin
      k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    end else if (sel < 55 && inserted_keys.size() > 0) begin
      k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      k[$urandom_range(15)] ^= 1'b1;
    end else if (sel < 58) begin
      k = ALL_ONES;
    end else begin
      k = 16'($urandom);
    end
    return k;
  endfunction

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    int i;
    logic op;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      op = ($urandom_range(99) < 45) ? ptri_pkg::OP_INSERT : ptri_pkg::OP_LOOKUP;
      send_request(op, pick_key());
    end
  endtask

  initial begin
    int i;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_sent = 0;
    wdog = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty trie, reserved key, extremes, duplicates, single bit keys
    send_request(ptri_pkg::OP_LOOKUP, 16'h0000);
    send_request(ptri_pkg::OP_LOOKUP, ALL_ONES);
    send_request(ptri_pkg::OP_INSERT, ALL_ONES);
    send_request(ptri_pkg::OP_INSERT, 16'h0000);
    send_request(ptri_pkg::OP_INSERT, 16'h0000);
    send_request(ptri_pkg::OP_LOOKUP, 16'h0000);
    send_request(ptri_pkg::OP_INSERT, 16'hFFFE);
    send_request(ptri_pkg::OP_INSERT, 16'h7FFF);
    send_request(ptri_pkg::OP_INSERT, 16'h8000);
    send_request(ptri_pkg::OP_INSERT, 16'h0001);
    send_request(ptri_pkg::OP_LOOKUP, 16'hFFFE);
    send_request(ptri_pkg::OP_LOOKUP, 16'h0002);
    send_request(ptri_pkg::OP_INSERT, 16'hAAAA);
    send_request(ptri_pkg::OP_INSERT, 16'h5555);
    send_request(ptri_pkg::OP_LOOKUP, 16'h5555);
    send_request(ptri_pkg::OP_LOOKUP, 16'hAAAB);

    // random phases; the pool fills partway through and full answers follow
    run_phase(350, 0, 0);
    run_phase(350, 56, 0);
    run_phase(350, 0, 56);
    run_phase(350, 9, 9);

    // once full, every new-key insert must be refused
    for (i = 0; i < 20; i++) send_request(ptri_pkg::OP_INSERT, 16'($urandom));
    run_phase(260, 0, 0);
    req.valid <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d requests, %0d nodes in use, %0d results checked", n_sent, sb.used,
             sb.n_checked);
    $display("found %0d, not found %0d, inserted %0d, present %0d, full %0d, reserved %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_patricia_trie_insert_lookup: clean");
    end else begin
      $display("tb_patricia_trie_insert_lookup: errors");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/ptri_pkg.sv
rtl/ptri_if.sv
rtl/patricia_trie_insert_lookup.sv
verif/tb_patricia_trie_insert_lookup.sv
